>>> sv/mbc3_rtc_pkg.sv
// Package for the MBC3 bank controller with real-time clock.
// Holds the operation and access codes, the clock command struct and small helpers.
// No dependencies; used by mbc3_rtc_clock and mbc3_bank_controller_rtc_top.
package mbc3_rtc_pkg;

	localparam logic [1:0] OP_READ   = 2'd0;
	localparam logic [1:0] OP_WRITE  = 2'd1;
	localparam logic [1:0] OP_TICK   = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef enum logic [2:0] {
		KIND_NONE      = 3'd0,
		KIND_ROM_READ  = 3'd1,
		KIND_RAM_READ  = 3'd2,
		KIND_RAM_WRITE = 3'd3,
		KIND_RTC_READ  = 3'd4,
		KIND_REG_WRITE = 3'd5
	} access_kind_t;

	localparam logic CFG_ROM_SIZE = 1'b0;
	localparam logic CFG_RAM_SIZE = 1'b1;

	localparam logic [2:0] ROM_SIZE_RESET = 3'd6;
	localparam logic [2:0] RAM_SIZE_RESET = 3'd3;

	localparam logic [2:0] RTC_SECONDS = 3'd0;
	localparam logic [2:0] RTC_MINUTES = 3'd1;
	localparam logic [2:0] RTC_HOURS   = 3'd2;
	localparam logic [2:0] RTC_DAY_LO  = 3'd3;
	localparam logic [2:0] RTC_DAY_HI  = 3'd4;
	localparam int unsigned RTC_REGS   = 5;

	localparam logic [7:0] RAM_ON_BYTE   = 8'h0A;
	localparam logic [7:0] SEL_RTC_FIRST = 8'h08;
	localparam logic [7:0] SEL_RTC_LAST  = 8'h0C;

	typedef struct packed {
		logic       tick;
		logic       rtc_we;
		logic [2:0] rtc_idx;
		logic [7:0] wr_data;
		logic       latch;
		logic [2:0] rd_idx;
	} clock_cmd_t;

	// Remainder by 60 of a byte, by restoring subtraction of 240, 120 and 60.
	function automatic logic [5:0] mod60(input logic [7:0] v);
		logic [7:0] r;
		r = v;
		if (r >= 8'd240) r = r - 8'd240;
		if (r >= 8'd120) r = r - 8'd120;
		if (r >= 8'd60)  r = r - 8'd60;
		return r[5:0];
	endfunction

	// Remainder by 24 of a byte, by restoring subtraction of 192, 96, 48 and 24.
	function automatic logic [4:0] mod24(input logic [7:0] v);
		logic [7:0] r;
		r = v;
		if (r >= 8'd192) r = r - 8'd192;
		if (r >= 8'd96)  r = r - 8'd96;
		if (r >= 8'd48)  r = r - 8'd48;
		if (r >= 8'd24)  r = r - 8'd24;
		return r[4:0];
	endfunction

	// Number of 8 KiB RAM banks that a RAM size code describes.
	function automatic logic [4:0] ram_code_banks(input logic [2:0] code);
		logic [4:0] b;
		case (code)
			3'd2:    b = 5'd1;
			3'd3:    b = 5'd4;
			3'd4:    b = 5'd16;
			3'd5:    b = 5'd8;
			default: b = 5'd0;
		endcase
		return b;
	endfunction

endpackage

>>> sv/mbc3_rtc_clock.sv
// Live real-time clock counters and the latched copy of the clock registers.
// Driven by a command struct from the top level; depends on mbc3_rtc_pkg.
// Seconds, minutes, hours, a 9-bit day counter with sticky carry, and halt.
module mbc3_rtc_clock (
	input  logic                     clk,
	input  logic                     arst_n,
	input  mbc3_rtc_pkg::clock_cmd_t cmd,
	output logic [7:0]               rd_data
);

	logic [5:0] sec_q;
	logic [5:0] min_q;
	logic [4:0] hour_q;
	logic [8:0] day_q;
	logic       carry_q;
	logic       halt_q;
	logic [7:0] latch_q [mbc3_rtc_pkg::RTC_REGS];

	logic       sec_wrap;
	logic       min_wrap;
	logic       hour_wrap;
	logic [5:0] sec_inc;
	logic [5:0] min_inc;
	logic [4:0] hour_inc;

	assign sec_inc   = sec_q + 6'd1;
	assign min_inc   = min_q + 6'd1;
	assign hour_inc  = hour_q + 5'd1;
	assign sec_wrap  = sec_inc >= 6'd60;
	assign min_wrap  = min_inc >= 6'd60;
	assign hour_wrap = hour_inc >= 5'd24;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q   <= '0;
			min_q   <= '0;
			hour_q  <= '0;
			day_q   <= '0;
			carry_q <= 1'b0;
			halt_q  <= 1'b0;
		end else if (cmd.tick && !halt_q) begin
			if (!sec_wrap) begin
				sec_q <= sec_inc;
			end else begin
				sec_q <= '0;
				if (!min_wrap) begin
					min_q <= min_inc;
				end else begin
					min_q <= '0;
					if (!hour_wrap) begin
						hour_q <= hour_inc;
					end else begin
						hour_q <= '0;
						day_q  <= day_q + 9'd1;
						if (day_q == 9'h1FF) begin
							carry_q <= 1'b1;
						end
					end
				end
			end
		end else if (cmd.rtc_we) begin
			unique case (cmd.rtc_idx)
				mbc3_rtc_pkg::RTC_SECONDS: sec_q  <= mbc3_rtc_pkg::mod60(cmd.wr_data);
				mbc3_rtc_pkg::RTC_MINUTES: min_q  <= mbc3_rtc_pkg::mod60(cmd.wr_data);
				mbc3_rtc_pkg::RTC_HOURS:   hour_q <= mbc3_rtc_pkg::mod24(cmd.wr_data);
				mbc3_rtc_pkg::RTC_DAY_LO:  day_q  <= {day_q[8], cmd.wr_data};
				default: begin
					day_q   <= {cmd.wr_data[0], day_q[7:0]};
					halt_q  <= cmd.wr_data[6];
					carry_q <= cmd.wr_data[7];
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mbc3_rtc_pkg::RTC_REGS; i++) begin
				latch_q[i] <= '0;
			end
		end else if (cmd.latch) begin
			latch_q[mbc3_rtc_pkg::RTC_SECONDS] <= {2'b00, sec_q};
			latch_q[mbc3_rtc_pkg::RTC_MINUTES] <= {2'b00, min_q};
			latch_q[mbc3_rtc_pkg::RTC_HOURS]   <= {3'b000, hour_q};
			latch_q[mbc3_rtc_pkg::RTC_DAY_LO]  <= day_q[7:0];
			latch_q[mbc3_rtc_pkg::RTC_DAY_HI]  <= {carry_q, halt_q, 5'b00000, day_q[8]};
		end
	end

	always_comb begin
		rd_data = latch_q[mbc3_rtc_pkg::RTC_DAY_HI];
		if (cmd.rd_idx < mbc3_rtc_pkg::RTC_DAY_HI) begin
			rd_data = latch_q[cmd.rd_idx];
		end
	end

endmodule

>>> sv/mbc3_bank_controller_rtc_top.sv
// MBC3 bank controller with real-time clock: top level. Depends on mbc3_rtc_pkg, mbc3_rtc_clock.
// Throughput: one item per cycle while m_tready lets results drain; an input register feeds
// one pass of decode and state update that lands in the result register.
// Reset clears the handshake state, the clock and the other bank registers, sets the
// ROM bank to 1, and loads the size registers with ROM code 6 and RAM code 3.
module mbc3_bank_controller_rtc_top #(
	parameter int unsigned RAM_BANKS     = 8,
	parameter int unsigned ROM_BANK_BITS = 7
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// Fields from bit 0: operation[1:0], address[17:2], data[25:18], zero fill.
	input  logic [31:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// Fields from bit 0: access_kind[2:0], rom_address[23:3], ram_address[39:24],
	// write_data[47:40], read_data[55:48].
	output logic [55:0] m_tdata,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [2:0]  cfg_data
);

	localparam logic [4:0] RamCap = 5'(RAM_BANKS);
	localparam logic [6:0] BankMask = 7'((1 << ROM_BANK_BITS) - 1);

	logic [2:0] rom_size_q;
	logic [2:0] ram_size_q;

	logic        valid_s1;
	logic [1:0]  op_s1;
	logic [15:0] addr_s1;
	logic [7:0]  data_s1;
	logic        advance;

	logic                     ram_en_q;
	logic [ROM_BANK_BITS-1:0] rom_bank_q;
	logic [7:0]               sel_q;
	logic [7:0]               prev_latch_q;

	logic                     ram_en_d;
	logic [ROM_BANK_BITS-1:0] rom_bank_d;
	logic [7:0]               sel_d;
	logic [7:0]               prev_latch_d;

	mbc3_rtc_pkg::clock_cmd_t     cmd;
	mbc3_rtc_pkg::access_kind_t   kind;
	logic [7:0]                   rtc_rd_data;
	logic [20:0]                  rom_a;
	logic [15:0]                  ram_a;
	logic [7:0]                   wdat;
	logic [7:0]                   rdat;

	logic [8:0]                   bank_count;
	logic [8:0]                   bank_count_m1;
	logic [6:0]                   bank_wide;
	logic [6:0]                   bank_new;
	logic [4:0]                   ram_banks;
	logic [4:0]                   ram_limit;
	logic                         ram_window;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_size_q <= mbc3_rtc_pkg::ROM_SIZE_RESET;
			ram_size_q <= mbc3_rtc_pkg::RAM_SIZE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mbc3_rtc_pkg::CFG_ROM_SIZE: rom_size_q <= cfg_data;
				default:                    ram_size_q <= cfg_data;
			endcase
		end
	end

	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= s_tdata[1:0];
			addr_s1 <= s_tdata[17:2];
			data_s1 <= s_tdata[25:18];
		end
	end

	assign bank_count    = 9'd2 << rom_size_q;
	assign bank_count_m1 = bank_count - 9'd1;
	assign bank_wide     = 7'(rom_bank_q);
	assign bank_new      = data_s1[6:0] & bank_count_m1[6:0] & BankMask;
	assign ram_banks     = mbc3_rtc_pkg::ram_code_banks(ram_size_q);
	assign ram_limit     = (ram_banks < RamCap) ? ram_banks : RamCap;
	assign ram_window    = (addr_s1[15:13] == 3'b101);

	always_comb begin
		kind         = mbc3_rtc_pkg::KIND_NONE;
		rom_a        = '0;
		ram_a        = '0;
		wdat         = '0;
		ram_en_d     = ram_en_q;
		rom_bank_d   = rom_bank_q;
		sel_d        = sel_q;
		prev_latch_d = prev_latch_q;
		cmd          = '0;
		cmd.wr_data  = data_s1;
		cmd.rd_idx   = sel_q[2:0];
		cmd.rtc_idx  = sel_q[2:0];

		if (op_s1 == mbc3_rtc_pkg::OP_TICK) begin
			cmd.tick = advance;
		end else if (op_s1 == mbc3_rtc_pkg::OP_READ && addr_s1[15:14] == 2'b00) begin
			kind  = mbc3_rtc_pkg::KIND_ROM_READ;
			rom_a = {7'd0, addr_s1[13:0]};
		end else if (op_s1 == mbc3_rtc_pkg::OP_READ && !addr_s1[15]) begin
			if ({2'b00, bank_wide} < bank_count) begin
				kind  = mbc3_rtc_pkg::KIND_ROM_READ;
				rom_a = {bank_wide, addr_s1[13:0]};
			end
		end else if (op_s1 == mbc3_rtc_pkg::OP_WRITE && !addr_s1[15]) begin
			kind = mbc3_rtc_pkg::KIND_REG_WRITE;
			unique case (addr_s1[14:13])
				2'b00: begin
					if (data_s1 == mbc3_rtc_pkg::RAM_ON_BYTE) begin
						ram_en_d = 1'b1;
					end else if (data_s1 == 8'h00) begin
						ram_en_d = 1'b0;
					end
				end
				2'b01: begin
					rom_bank_d = (bank_new == 7'd0) ? ROM_BANK_BITS'(1) :
						bank_new[ROM_BANK_BITS-1:0];
				end
				2'b10: begin
					sel_d = data_s1;
				end
				default: begin
					cmd.latch    = advance && prev_latch_q == 8'h00 && data_s1 == 8'h01;
					prev_latch_d = data_s1;
				end
			endcase
		end else if (!op_s1[1] && ram_window && ram_en_q) begin
			if (sel_q[7:3] == 5'd0) begin
				if ({2'b00, sel_q[2:0]} < ram_limit) begin
					ram_a = {sel_q[2:0], addr_s1[12:0]};
					if (op_s1 == mbc3_rtc_pkg::OP_READ) begin
						kind = mbc3_rtc_pkg::KIND_RAM_READ;
					end else begin
						kind = mbc3_rtc_pkg::KIND_RAM_WRITE;
						wdat = data_s1;
					end
				end
			end else if (sel_q <= mbc3_rtc_pkg::SEL_RTC_LAST) begin
				if (op_s1 == mbc3_rtc_pkg::OP_READ) begin
					kind = mbc3_rtc_pkg::KIND_RTC_READ;
				end else begin
					kind       = mbc3_rtc_pkg::KIND_REG_WRITE;
					cmd.rtc_we = advance;
				end
			end
		end

		rdat = 8'h00;
		if (kind == mbc3_rtc_pkg::KIND_NONE) begin
			rdat = 8'hFF;
		end else if (kind == mbc3_rtc_pkg::KIND_RTC_READ) begin
			rdat = rtc_rd_data;
		end
	end

	mbc3_rtc_clock u_clock (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.rd_data (rtc_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_en_q     <= 1'b0;
			rom_bank_q   <= ROM_BANK_BITS'(1);
			sel_q        <= '0;
			prev_latch_q <= '0;
		end else if (advance) begin
			ram_en_q     <= ram_en_d;
			rom_bank_q   <= rom_bank_d;
			sel_q        <= sel_d;
			prev_latch_q <= prev_latch_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_tdata <= {rdat, wdat, ram_a, rom_a, kind};
		end
	end

endmodule
